[rtl/ffba_pkg.sv]
// Shared constants, opcodes and the step-unit flag type of the first-fit block allocator.
// No dependencies; imported by ffba_step, the allocator core and the checker.
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

   // Default arena geometry
   localparam int ARENA_BYTES_DEF   = 4096;
   localparam int GRANULE_BYTES_DEF = 16;

   // Fixed field widths
   localparam int REQ_W      = 16;   // request_bytes
   localparam int OFFSET_W   = 12;   // payload_offset
   localparam int REQ_DATA_W = 16;   // request tdata, whole bytes
   localparam int RSP_DATA_W = 16;   // result tdata, whole bytes

   // Opcodes carried in the request tuser
   localparam logic OP_INIT  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   // Flags from the header step unit
   typedef struct packed {
      logic fit;        // free and large enough
      logic split;      // remainder holds a header and one granule
      logic rest_ok;    // remainder header lies inside the arena
      logic exhausted;  // next header lies beyond the arena
   } ffba_step_flags_type;

endpackage : ffba_pkg

`default_nettype wire

[rtl/ffba_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies; holds the allocator's header store.
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule : ffba_ram

`default_nettype wire

[rtl/ffba_step.sv]
// Shared compare/add unit: judges one block header against the request.
// Depends on ffba_pkg for the flag struct.
`timescale 1ns / 1ps
`default_nettype none

module ffba_step
   import ffba_pkg::*;
#(
   parameter int GRANULES = 256,
   parameter int IDX_W    = 8,
   parameter int NEED_W   = 13
) (
   input  wire logic [IDX_W:0]    pos,
   input  wire logic              hdr_free,
   input  wire logic [IDX_W-1:0]  hdr_size,
   input  wire logic [NEED_W-1:0] need,
   output ffba_step_flags_type    flags,
   output logic      [IDX_W:0]    next_pos,
   output logic      [IDX_W:0]    rest_pos,
   output logic      [IDX_W-1:0]  rest_size
);

   localparam int POS_W = IDX_W + 1;
   localparam int CMP_W = ((IDX_W > NEED_W) ? IDX_W : NEED_W) + 2;

   logic [CMP_W-1:0] size_c;
   logic [CMP_W-1:0] need_c;

   always_comb begin
      size_c = CMP_W'(hdr_size);
      need_c = CMP_W'(need);

      flags.fit   = hdr_free && (size_c >= need_c);
      flags.split = size_c >= (need_c + CMP_W'(2));

      // only meaningful on a fit, where need is below the granule count
      rest_pos      = pos + POS_W'(1) + POS_W'(need);
      flags.rest_ok = rest_pos < POS_W'(GRANULES);
      rest_size     = hdr_size - IDX_W'(need) - IDX_W'(1);

      next_pos        = pos + POS_W'(1) + POS_W'(hdr_size);
      flags.exhausted = next_pos >= POS_W'(GRANULES);
   end

endmodule : ffba_step

`default_nettype wire

[rtl/first_fit_block_allocator_core.sv]
// First-fit block allocator over an arena of fixed-size granules, header walk in a RAM.
// Depends on ffba_pkg, ffba_ram and ffba_step.
`timescale 1ns / 1ps
`default_nettype none

// Sequence: a reinitialise goes from S_IDLE straight to S_DONE; an allocate visiting k
//   headers passes S_READ and S_EVAL once per header, then S_DONE when nothing fits,
//   S_MARK and S_DONE for a grant, and S_SPLIT, S_MARK and S_DONE with a split. Every
//   block spans at least two granules, so k <= GRANULES/2.
// One item at a time; each header step is a RAM read, then a compare of the header read.
// req_tready is high only while the sequencer idles; a waiting result holds the next one.
// Reset (synchronous, active high) clears the sequencer and the result valid flag and marks
//   entry 0 as the single free block; the header RAM itself is not cleared.

module first_fit_block_allocator_core
   import ffba_pkg::*;
#(
   parameter int ARENA_BYTES   = ARENA_BYTES_DEF,
   parameter int GRANULE_BYTES = GRANULE_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] request_bytes
   input  wire logic [0:0]            req_tuser,   // [0] opcode
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,   // [11:0] payload_offset, [15:12] zero
   output logic      [0:0]            rsp_tuser    // [0] granted
);

   localparam int GRANULES = ARENA_BYTES / GRANULE_BYTES;
   localparam int IDX_W    = $clog2(GRANULES);
   localparam int POS_W    = IDX_W + 1;
   localparam int HDR_W    = IDX_W + 1;          // {free, size}
   localparam int SHIFT    = $clog2(GRANULE_BYTES);
   localparam int NEED_W   = REQ_W + 1 - SHIFT;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,   // issue header read at the walk position
      S_EVAL  = 6'b000100,   // judge the header just read
      S_SPLIT = 6'b001000,   // write the free header of the remainder
      S_MARK  = 6'b010000,   // write the taken header
      S_DONE  = 6'b100000    // hand the result to the output register
   } state_type;

   state_type state_ff, state_in;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic [IDX_W-1:0]    rest_addr_ff, rest_addr_in;
   logic [IDX_W-1:0]    rest_size_ff, rest_size_in;
   logic [IDX_W-1:0]    mark_size_ff, mark_size_in;
   logic                res_granted_ff, res_granted_in;
   logic [OFFSET_W-1:0] res_offset_ff, res_offset_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_granted_ff, rsp_granted_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic                fresh_ff, fresh_in;         // entry 0 still holds the whole-arena block
   logic                rd_fresh_ff, rd_fresh_in;

   logic                req_fire;
   logic [REQ_W-1:0]    req_nz;
   logic [REQ_W:0]      req_round;
   logic                ram_we;
   logic [IDX_W-1:0]    ram_addr;
   logic [HDR_W-1:0]    ram_wdata;
   logic [HDR_W-1:0]    ram_rdata;
   logic                hdr_free;
   logic [IDX_W-1:0]    hdr_size;
   logic [31:0]         off_wide;
   logic                slot_free;

   ffba_step_flags_type step_flags;
   logic [POS_W-1:0]    step_next;
   logic [POS_W-1:0]    step_rest_pos;
   logic [IDX_W-1:0]    step_rest_size;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Round the request up to whole granules; zero counts as one granule
   assign req_nz    = (req_tdata == '0) ? REQ_W'(1) : req_tdata[REQ_W-1:0];
   assign req_round = {1'b0, req_nz} + (REQ_W + 1)'(GRANULE_BYTES - 1);

   // Header store: the remainder header is written in S_SPLIT, the taken one in S_MARK
   always_comb begin
      ram_we    = (state_ff == S_SPLIT) || (state_ff == S_MARK);
      ram_addr  = pos_ff[IDX_W-1:0];
      ram_wdata = {1'b0, mark_size_ff};
      if (state_ff == S_SPLIT) begin
         ram_addr  = rest_addr_ff;
         ram_wdata = {1'b1, rest_size_ff};
      end
   end

   ffba_ram #(
      .WIDTH (HDR_W),
      .DEPTH (GRANULES)
   ) u_hdr_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // The walk only ever lands on entry 0 or on a header written since the last reset or
   // reinitialise, so only entry 0 needs a reset value: the single free block.
   always_comb begin
      if (rd_fresh_ff) begin
         hdr_free = 1'b1;
         hdr_size = IDX_W'(GRANULES - 1);
      end else begin
         hdr_free = ram_rdata[IDX_W];
         hdr_size = ram_rdata[IDX_W-1:0];
      end
   end

   ffba_step #(
      .GRANULES (GRANULES),
      .IDX_W    (IDX_W),
      .NEED_W   (NEED_W)
   ) u_step (
      .pos       (pos_ff),
      .hdr_free  (hdr_free),
      .hdr_size  (hdr_size),
      .need      (need_ff),
      .flags     (step_flags),
      .next_pos  (step_next),
      .rest_pos  (step_rest_pos),
      .rest_size (step_rest_size)
   );

   // Payload starts one granule past the header; keep the low offset bits
   assign off_wide = 32'(pos_ff + POS_W'(1)) << SHIFT;

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      need_in        = need_ff;
      rest_addr_in   = rest_addr_ff;
      rest_size_in   = rest_size_ff;
      mark_size_in   = mark_size_ff;
      res_granted_in = res_granted_ff;
      res_offset_in  = res_offset_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_granted_in = rsp_granted_ff;
      rsp_offset_in  = rsp_offset_ff;
      fresh_in       = fresh_ff;

      // Note whether this read hits the untouched entry 0; drop the mark once it is written
      rd_fresh_in = fresh_ff && (ram_addr == '0);
      if (ram_we && (ram_addr == '0)) begin
         fresh_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pos_in         = '0;
               need_in        = NEED_W'(req_round >> SHIFT);
               res_granted_in = 1'b0;
               res_offset_in  = '0;
               if (req_tuser[0] == OP_INIT) begin
                  // entry 0 reads as one free block again; older headers become unreachable
                  fresh_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (step_flags.fit) begin
               rest_addr_in = step_rest_pos[IDX_W-1:0];
               rest_size_in = step_rest_size;
               mark_size_in = step_flags.split ? IDX_W'(need_ff) : hdr_size;
               state_in     = (step_flags.split && step_flags.rest_ok) ? S_SPLIT : S_MARK;
            end else if (step_flags.exhausted) begin
               state_in = S_DONE;
            end else begin
               pos_in   = step_next;
               state_in = S_READ;
            end
         end
         S_SPLIT: begin
            state_in = S_MARK;
         end
         S_MARK: begin
            res_granted_in = 1'b1;
            res_offset_in  = off_wide[OFFSET_W-1:0];
            state_in       = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_offset_in  = res_offset_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fresh_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fresh_ff     <= fresh_in;
      end
      pos_ff         <= pos_in;
      need_ff        <= need_in;
      rest_addr_ff   <= rest_addr_in;
      rest_size_ff   <= rest_size_in;
      mark_size_ff   <= mark_size_in;
      res_granted_ff <= res_granted_in;
      res_offset_ff  <= res_offset_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_offset_ff  <= rsp_offset_in;
      rd_fresh_ff    <= rd_fresh_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_offset_ff);
   assign rsp_tuser  = rsp_granted_ff;

endmodule : first_fit_block_allocator_core

`default_nettype wire

[rtl/ffba_checker.sv]
// Port-level checks for the first-fit block allocator, bound to its top level.
// Depends on ffba_pkg and first_fit_block_allocator_core.
`timescale 1ns / 1ps
`default_nettype none

module ffba_checker
   import ffba_pkg::*;
#(
   parameter int GRANULE_BYTES = GRANULE_BYTES_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [0:0]            rsp_tuser
);

   localparam int SHIFT = $clog2(GRANULE_BYTES);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A refused or reinitialise result carries a zero offset
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("non-granted result with non-zero offset");

   // A granted payload starts on a granule boundary and padding stays zero
   a_grant_align: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0]
         |-> rsp_tdata[SHIFT-1:0] == '0 && rsp_tdata[RSP_DATA_W-1:OFFSET_W] == '0)
      else $error("granted offset misaligned");

   // One item at a time: the block is busy the cycle after a transfer in
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule : ffba_checker

bind first_fit_block_allocator_core ffba_checker #(
   .GRANULE_BYTES (GRANULE_BYTES)
) u_ffba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
